>>> rtl/qpsd_pkg.sv
// ----------------------------------------------------------------------------
// qpsd_pkg: shared types for the quadrature position and speed decoder
// Widths and the request/response bundles of the shared iterative divider.
// ----------------------------------------------------------------------------
package qpsd_pkg;

  // Divider operand widths: 33-bit dividend covers a 32-bit count plus one.
  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

>>> rtl/qpsd_div.sv
// ----------------------------------------------------------------------------
// qpsd_div: shared iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpsd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  qpsd_pkg::div_req_t  req,
  output qpsd_pkg::div_rsp_t  rsp
);
  import qpsd_pkg::*;

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, quo_r[DIVIDEND_W-1]};
    fits     = shifted >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_nxt = fits ? DIVISOR_W'(shifted - {1'b0, dvs_r}) : DIVISOR_W'(shifted);
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/quadrature_position_speed_decoder_top.sv
// ----------------------------------------------------------------------------
// quadrature_position_speed_decoder_top: x4 quadrature decoder with speed
// Decodes A/B edge events into pulse count, angle, direction, period and
// signed speed, using one shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   in      | in_kind, in_level_a, in_level_b, in_time_us | in_valid / in_stall
//   out     | out_pulse_count .. out_pulse_done       | out_valid / out_stall
//   cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// A request that does not complete a pulse goes from idle via the result state
// to the result register; a completing one first runs two 33-step divider
// passes (speed quotient, then count modulo) at one quotient bit per cycle.
// in_stall is high from acceptance until the sequencer is back in idle.
// The result register frees the input side while a result waits under
// out_stall. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module quadrature_position_speed_decoder_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_level_a,
  input  logic        in_level_b,
  input  logic [31:0] in_time_us,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pulse_count,
  output logic [47:0] out_angle,
  output logic [1:0]  out_direction,
  output logic [31:0] out_period_us,
  output logic signed [32:0] out_speed,
  output logic        out_pulse_done,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import qpsd_pkg::*;

  // register indexes
  localparam logic [1:0] REG_PPR = 2'd0;
  localparam logic [1:0] REG_APP = 2'd1;
  localparam logic [1:0] REG_NUM = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_STILL = 2'd0;
  localparam logic [1:0] DIR_CW    = 2'd1;
  localparam logic [1:0] DIR_ACW   = 2'd2;

  localparam logic [2:0] STEPS_PER_PULSE = 3'd4;
  localparam logic [0:0] KIND_ZERO       = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPEED,
    S_MOD,
    S_RESULT
  } state_t;

  // next clockwise phase: 00 -> 10 -> 11 -> 01 -> 00
  function automatic logic [1:0] cw_next(input logic [1:0] p);
    logic [1:0] n;
    case (p)
      2'b00:   n = 2'b10;
      2'b10:   n = 2'b11;
      2'b11:   n = 2'b01;
      default: n = 2'b00;
    endcase
    return n;
  endfunction

  // configuration registers
  logic [15:0] ppr_r;
  logic [31:0] app_r;
  logic [31:0] num_r;

  // decoder state
  state_t                  state_r, state_nxt;
  logic [1:0]              quad_phase_r, quad_phase_nxt;
  logic [1:0]              motion_dir_r, motion_dir_nxt;
  logic [2:0]              step_count_r, step_count_nxt;
  logic [COUNT_BITS-1:0]   pulses_r, pulses_nxt;
  logic [31:0]             period_start_r, period_start_nxt;
  logic [31:0]             last_period_r, last_period_nxt;
  logic [32:0]             last_speed_r, last_speed_nxt;
  logic                    pulse_cw_r, pulse_cw_nxt;
  logic                    done_r, done_nxt;

  // divider request, registered
  div_req_t                div_req_r, div_req_nxt;
  div_rsp_t                div_rsp;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             out_cnt_r, out_cnt_nxt;
  logic [47:0]             out_angle_r, out_angle_nxt;
  logic [1:0]              out_dir_r, out_dir_nxt;
  logic [31:0]             out_period_r, out_period_nxt;
  logic [32:0]             out_speed_r, out_speed_nxt;
  logic                    out_done_r, out_done_nxt;

  // step decode
  logic [1:0]  in_phase;
  logic        is_cw, is_acw;
  logic [1:0]  step_dir;
  logic [2:0]  sc_base, sc_new;
  logic [31:0] start_base, period_raw, period_eff;
  logic [15:0] ppr_eff, rem16, cnt16;
  logic [47:0] angle_prod;
  logic        accept;

  qpsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    in_phase   = {in_level_a, in_level_b};
    is_cw      = (in_phase == cw_next(quad_phase_r));
    is_acw     = (quad_phase_r == cw_next(in_phase));
    step_dir   = is_cw ? DIR_CW : DIR_ACW;
    // restart the sub-step count from still or on reversal
    sc_base    = (motion_dir_r == DIR_STILL || motion_dir_r != step_dir) ? 3'd0
                                                                         : step_count_r;
    sc_new     = sc_base + 3'd1;
    start_base = (motion_dir_r == DIR_STILL) ? in_time_us : period_start_r;
    period_raw = in_time_us - start_base;
    period_eff = (period_raw == 32'd0) ? 32'd1 : period_raw;
    ppr_eff    = (ppr_r == 16'd0) ? 16'd1 : ppr_r;
    rem16      = div_rsp.remainder[15:0];
    cnt16      = 16'(pulses_r);
    angle_prod = 48'(cnt16) * 48'(app_r);
  end

  always_comb begin
    state_nxt        = state_r;
    quad_phase_nxt   = quad_phase_r;
    motion_dir_nxt   = motion_dir_r;
    step_count_nxt   = step_count_r;
    pulses_nxt       = pulses_r;
    period_start_nxt = period_start_r;
    last_period_nxt  = last_period_r;
    last_speed_nxt   = last_speed_r;
    pulse_cw_nxt     = pulse_cw_r;
    done_nxt         = done_r;
    div_req_nxt      = div_req_r;
    div_req_nxt.start = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_cnt_nxt      = out_cnt_r;
    out_angle_nxt    = out_angle_r;
    out_dir_nxt      = out_dir_r;
    out_period_nxt   = out_period_r;
    out_speed_nxt    = out_speed_r;
    out_done_nxt     = out_done_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          done_nxt  = 1'b0;
          state_nxt = S_RESULT;
          if (in_kind == KIND_ZERO) begin
            pulses_nxt     = '0;
            motion_dir_nxt = DIR_STILL;
            quad_phase_nxt = in_phase;
          end else if (is_cw || is_acw) begin
            quad_phase_nxt   = in_phase;
            motion_dir_nxt   = step_dir;
            step_count_nxt   = sc_new;
            period_start_nxt = start_base;
            if (sc_new >= STEPS_PER_PULSE) begin
              // pulse complete: measure period, divide for speed
              step_count_nxt       = 3'd0;
              period_start_nxt     = in_time_us;
              last_period_nxt      = period_eff;
              pulse_cw_nxt         = is_cw;
              div_req_nxt.start    = 1'b1;
              div_req_nxt.dividend = DIVIDEND_W'(num_r);
              div_req_nxt.divisor  = period_eff;
              state_nxt            = S_SPEED;
            end
          end
        end
      end

      S_SPEED: begin
        if (div_rsp.done) begin
          last_speed_nxt = pulse_cw_r ? {1'b0, div_rsp.quotient[31:0]}
                                      : 33'(33'd0 - {1'b0, div_rsp.quotient[31:0]});
          // reduce the stepped count modulo pulses per revolution
          div_req_nxt.start    = 1'b1;
          div_req_nxt.dividend = pulse_cw_r ? DIVIDEND_W'(pulses_r) + DIVIDEND_W'(1)
                                            : DIVIDEND_W'(pulses_r);
          div_req_nxt.divisor  = DIVISOR_W'(ppr_eff);
          state_nxt            = S_MOD;
        end
      end

      S_MOD: begin
        if (div_rsp.done) begin
          if (pulse_cw_r) begin
            pulses_nxt = COUNT_BITS'(rem16);
          end else begin
            pulses_nxt = (rem16 == 16'd0) ? COUNT_BITS'(ppr_eff - 16'd1)
                                          : COUNT_BITS'(rem16 - 16'd1);
          end
          done_nxt  = 1'b1;
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        // load the result register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_cnt_nxt    = cnt16;
          out_angle_nxt  = angle_prod;
          out_dir_nxt    = motion_dir_r;
          out_period_nxt = last_period_r;
          out_speed_nxt  = last_speed_r;
          out_done_nxt   = done_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      quad_phase_r      <= 2'b00;
      motion_dir_r      <= DIR_STILL;
      step_count_r      <= 3'd0;
      pulses_r          <= '0;
      period_start_r    <= 32'd0;
      last_period_r     <= 32'd0;
      last_speed_r      <= 33'd0;
      done_r            <= 1'b0;
      div_req_r.start   <= 1'b0;
      out_valid_r       <= 1'b0;
      ppr_r             <= 16'd1024;
      app_r             <= 32'd65536;
      num_r             <= 32'd65536;
    end else begin
      state_r           <= state_nxt;
      quad_phase_r      <= quad_phase_nxt;
      motion_dir_r      <= motion_dir_nxt;
      step_count_r      <= step_count_nxt;
      pulses_r          <= pulses_nxt;
      period_start_r    <= period_start_nxt;
      last_period_r     <= last_period_nxt;
      last_speed_r      <= last_speed_nxt;
      done_r            <= done_nxt;
      div_req_r.start   <= div_req_nxt.start;
      out_valid_r       <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PPR: ppr_r <= cfg_wdata[15:0];
          REG_APP: app_r <= cfg_wdata;
          REG_NUM: num_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    pulse_cw_r           <= pulse_cw_nxt;
    div_req_r.dividend   <= div_req_nxt.dividend;
    div_req_r.divisor    <= div_req_nxt.divisor;
    out_cnt_r            <= out_cnt_nxt;
    out_angle_r          <= out_angle_nxt;
    out_dir_r            <= out_dir_nxt;
    out_period_r         <= out_period_nxt;
    out_speed_r          <= out_speed_nxt;
    out_done_r           <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_count = out_cnt_r;
  assign out_angle       = out_angle_r;
  assign out_direction   = out_dir_r;
  assign out_period_us   = out_period_r;
  assign out_speed       = signed'(out_speed_r);
  assign out_pulse_done  = out_done_r;

`ifndef ASSERT_OFF
  // a completed pulse always reports motion
  a_done_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pulse_done) |-> (out_direction != DIR_STILL))
    else $error("pulse reported while still");

  // the sub-step count wraps at a full pulse
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_count_r < STEPS_PER_PULSE)
    else $error("sub-step count out of range");

  // never restart the divider in mid-division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req_r.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // a request enters only with the sequencer idle and leaves it busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer still idle after a request");
`endif

endmodule

>>> sim/quadrature_position_speed_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_position_speed_decoder_top_test: self-checking bench for the
// x4 quadrature decoder. Drives edge and set-zero requests, tracks the
// expected pulse count, angle, direction, period and speed in a local
// decoder model, and compares every response against it in order.
// ----------------------------------------------------------------------------
module quadrature_position_speed_decoder_top_test;

  localparam time     LIMIT_NS        = 20_000_000;
  localparam int      HOLD_CYCLES     = 400;
  localparam int      SETTLE_CYCLES   = 100;
  localparam int      RANDOM_ITEMS    = 430;
  localparam int      STEPS_PER_PULSE = 4;

  // request kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_ZERO = 1'b1;

  // rotation codes as reported on out_direction
  localparam logic [1:0] DIR_STILL = 2'd0;
  localparam logic [1:0] DIR_CW    = 2'd1;
  localparam logic [1:0] DIR_ACW   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PULSES_PER_REV  = 2'd0;
  localparam logic [1:0] REG_ANGLE_PER_PULSE = 2'd1;
  localparam logic [1:0] REG_SPEED_NUM       = 2'd2;

  typedef struct packed {
    logic [15:0] count;
    logic [47:0] angle;
    logic [1:0]  dir;
    logic [31:0] period;
    logic [32:0] speed;
    logic        done;
  } pos_report_t;

  // clock, reset and DUT ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        in_kind    = KIND_EDGE;
  logic        in_level_a = 1'b0;
  logic        in_level_b = 1'b0;
  logic [31:0] in_time_us = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [15:0] out_pulse_count;
  logic [47:0] out_angle;
  logic [1:0]  out_direction;
  logic [31:0] out_period_us;
  logic signed [32:0] out_speed;
  logic        out_pulse_done;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_PULSES_PER_REV;
  logic [31:0] cfg_wdata  = '0;

  // decoder model: configuration copy, taken from the reset values
  logic [15:0] ppr_cfg = 16'd1024;
  logic [31:0] app_cfg = 32'd65536;
  logic [31:0] num_cfg = 32'd65536;

  // decoder model: rotation state
  logic [1:0]  phase_q   = 2'b00;
  logic [1:0]  dir_q     = DIR_STILL;
  logic [2:0]  steps_q   = '0;
  logic [15:0] count_q   = '0;
  logic [31:0] t_start_q = '0;
  logic [31:0] period_q  = '0;
  logic [32:0] speed_q   = '0;

  // responses still owed by the DUT, oldest first
  pos_report_t pending_reports[$];
  bit          failed = 1'b0;

  // timestamp of the next edge request
  logic [31:0] t_now = '0;

  // idle rates in percent per cycle for each side
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // long receiver hold-off: toggle hold_req to start one
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  always #6 clk = ~clk;

  quadrature_position_speed_decoder_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_level_a      (in_level_a),
    .in_level_b      (in_level_b),
    .in_time_us      (in_time_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_count (out_pulse_count),
    .out_angle       (out_angle),
    .out_direction   (out_direction),
    .out_period_us   (out_period_us),
    .out_speed       (out_speed),
    .out_pulse_done  (out_pulse_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Clockwise order is 00 -> 10 -> 11 -> 01 -> 00; anticlockwise is the reverse.
  function automatic logic [1:0] next_phase(input logic [1:0] p, input logic [1:0] dir);
    if (dir == DIR_CW) begin
      case (p)
        2'b00:   return 2'b10;
        2'b10:   return 2'b11;
        2'b11:   return 2'b01;
        default: return 2'b00;
      endcase
    end else begin
      case (p)
        2'b00:   return 2'b01;
        2'b01:   return 2'b11;
        2'b11:   return 2'b10;
        default: return 2'b00;
      endcase
    end
  endfunction

  // Advance the model by one accepted request and return the response it owes.
  function automatic pos_report_t decode_event(input logic kind, input logic a, input logic b,
                                               input logic [31:0] t);
    logic [1:0]  ph;
    logic [1:0]  dir;
    logic [31:0] per;
    logic [31:0] mag;
    logic [16:0] ppr;
    pos_report_t r;
    ph     = {a, b};
    dir    = DIR_STILL;
    r.done = 1'b0;
    if (kind == KIND_ZERO) begin
      // clear count and direction, load the phase; timer and speed stay
      count_q = '0;
      dir_q   = DIR_STILL;
      phase_q = ph;
    end else if (ph == next_phase(phase_q, DIR_CW)) begin
      dir = DIR_CW;
    end else if (ph == next_phase(phase_q, DIR_ACW)) begin
      dir = DIR_ACW;
    end
    // same phase or a two-step jump leaves dir at still: nothing moves
    if (dir != DIR_STILL) begin
      phase_q = ph;
      if (dir_q == DIR_STILL) begin
        // start from still: arm the pulse timer
        t_start_q = t;
        steps_q   = '0;
      end else if (dir_q != dir) begin
        // reversal: restart sub-step count, keep the timer
        steps_q = '0;
      end
      dir_q   = dir;
      steps_q = steps_q + 3'd1;
      if (steps_q >= STEPS_PER_PULSE) begin
        steps_q = '0;
        per     = t - t_start_q;
        if (per == 0) per = 32'd1;
        period_q = per;
        mag      = num_cfg / per;
        ppr      = (ppr_cfg == 0) ? 17'd1 : {1'b0, ppr_cfg};
        if (dir == DIR_CW) begin
          count_q = 16'(({1'b0, count_q} + 17'd1) % ppr);
          speed_q = {1'b0, mag};
        end else begin
          count_q = 16'(({1'b0, count_q} % ppr + ppr - 17'd1) % ppr);
          speed_q = 33'd0 - {1'b0, mag};
        end
        t_start_q = t;
        r.done    = 1'b1;
      end
    end
    r.count  = count_q;
    r.angle  = {32'd0, count_q} * {16'd0, app_cfg};
    r.dir    = dir_q;
    r.period = period_q;
    r.speed  = speed_q;
    return r;
  endfunction

  function automatic string show_report(input pos_report_t r);
    return $sformatf("count=%0d angle=%h dir=%0d period=%0d speed=%h done=%0d",
                     r.count, r.angle, r.dir, r.period, r.speed, r.done);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: compare each accepted response with the oldest one owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_responses
    pos_report_t got;
    pos_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pulse_count, out_angle, out_direction, out_period_us, out_speed,
             out_pulse_done};
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected response: expected none, actual %s", $time, show_report(got));
        failed = 1'b1;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t response mismatch: expected %s, actual %s", $time,
                   show_report(want), show_report(got));
          failed = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then record the response it owes.
  task automatic send_request(input logic kind, input logic a, input logic b,
                              input logic [31:0] t);
    // idle the sender at random before the offer
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_level_a <= a;
    in_level_b <= b;
    in_time_us <= t;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(decode_event(kind, a, b, t));
  endtask

  // Step n times in one direction, advancing the timestamp by dt after each.
  task automatic walk(input logic [1:0] dir, input int n, input logic [31:0] dt);
    logic [1:0] ph;
    repeat (n) begin
      ph = next_phase(phase_q, dir);
      send_request(KIND_EDGE, ph[1], ph[0], t_now);
      t_now += dt;
    end
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic drain_responses;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Write one register; only called while the DUT is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PULSES_PER_REV:  ppr_cfg = val[15:0];
      REG_ANGLE_PER_PULSE: app_cfg = val;
      REG_SPEED_NUM:       num_cfg = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Invalid steps, start from still, zero period, reversal, timestamp wrap,
  // count wrap below zero and set zero.
  task automatic test_directed;
    // same phase, then a two-step jump: both ignored
    send_request(KIND_EDGE, 1'b0, 1'b0, 32'd0);
    send_request(KIND_EDGE, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // start from still, one clockwise pulse of 150 us
    t_now = 32'd100;
    walk(DIR_CW, 4, 32'd50);
    // a pulse that ends on the timer start: zero period reads as one
    t_now = 32'd250;
    walk(DIR_CW, 4, 32'd0);
    // reverse: sub-step count restarts, timer keeps running
    t_now = 32'd300;
    walk(DIR_ACW, 4, 32'd10);
    // cross the timestamp wrap within one pulse
    t_now = 32'hFFFF_FFE0;
    walk(DIR_ACW, 4, 32'h10);
    // count at zero: step below zero to the top of the revolution
    t_now = 32'h20;
    walk(DIR_ACW, 4, 32'd1);
    // set zero with A high, then start again from still
    send_request(KIND_ZERO, 1'b1, 1'b0, 32'hFFFF_FFFF);
    t_now = 32'h100;
    walk(DIR_CW, 4, 32'd1);
  endtask

  // Register extremes: zero and full-range pulses per revolution, angle and
  // speed numerator at both ends, count left above a lowered range.
  task automatic test_config_extremes;
    drain_responses();
    write_reg(REG_PULSES_PER_REV, 32'd0);
    write_reg(REG_ANGLE_PER_PULSE, 32'hFFFF_FFFF);
    write_reg(REG_SPEED_NUM, 32'hFFFF_FFFF);
    t_now = 32'h2000;
    walk(DIR_CW, 4, 32'd0);
    walk(DIR_CW, 4, 32'd0);
    walk(DIR_ACW, 4, 32'd0);
    drain_responses();
    write_reg(REG_PULSES_PER_REV, 32'd65535);
    walk(DIR_ACW, 4, 32'd3);
    drain_responses();
    // count now 65534; lower the range so the next pulse folds it back
    write_reg(REG_PULSES_PER_REV, 32'd7);
    write_reg(REG_SPEED_NUM, 32'd0);
    walk(DIR_CW, 4, 32'd5);
    drain_responses();
    write_reg(REG_PULSES_PER_REV, 32'd1);
    write_reg(REG_ANGLE_PER_PULSE, 32'd0);
    walk(DIR_CW, 8, 32'd9);
    drain_responses();
    write_reg(REG_PULSES_PER_REV, 32'd1024);
    write_reg(REG_ANGLE_PER_PULSE, 32'd65536);
    write_reg(REG_SPEED_NUM, 32'd65536);
    walk(DIR_ACW, 8, 32'd2);
  endtask

  // Hold the receiver off while the sender keeps offering, so the DUT fills
  // and stalls its input; then pause the sender until all responses are in.
  task automatic test_hold_off;
    drain_responses();
    hold_req <= ~hold_req;
    t_now = 32'h8000;
    walk(DIR_CW, 30, 32'd7);
    drain_responses();
  endtask

  // Load random settings between random phases; small ranges make wraps common.
  task automatic load_random_config;
    drain_responses();
    case ($urandom_range(3))
      0:       write_reg(REG_PULSES_PER_REV, $urandom_range(1, 8));
      1:       write_reg(REG_PULSES_PER_REV, $urandom_range(0, 65535));
      2:       write_reg(REG_PULSES_PER_REV, $urandom_range(9, 64));
      default: write_reg(REG_PULSES_PER_REV, 32'd1024);
    endcase
    write_reg(REG_ANGLE_PER_PULSE, $urandom);
    write_reg(REG_SPEED_NUM, $urandom_range(1) ? $urandom : $urandom_range(0, 100000));
  endtask

  // Mostly steady rotation with random timing, plus reversals, invalid
  // steps, set-zero requests and fully random requests.
  task automatic test_random(input int n_items);
    int unsigned pick;
    logic [1:0]  dir;
    logic [1:0]  ph;
    repeat (n_items) begin
      pick = $urandom_range(99);
      dir  = (dir_q == DIR_STILL) ? ($urandom_range(1) ? DIR_CW : DIR_ACW) : dir_q;
      case ($urandom_range(19))
        0:       ;
        1:       t_now = $urandom;
        2:       t_now += $urandom_range(0, 1 << 20);
        default: t_now += $urandom_range(1, 2000);
      endcase
      if (pick < 68) begin
        ph = next_phase(phase_q, dir);
        send_request(KIND_EDGE, ph[1], ph[0], t_now);
      end else if (pick < 78) begin
        ph = next_phase(phase_q, (dir == DIR_CW) ? DIR_ACW : DIR_CW);
        send_request(KIND_EDGE, ph[1], ph[0], t_now);
      end else if (pick < 88) begin
        ph = $urandom_range(1) ? phase_q : (phase_q ^ 2'b11);
        send_request(KIND_EDGE, ph[1], ph[0], t_now);
      end else if (pick < 93) begin
        send_request(KIND_ZERO, 1'($urandom_range(1)), 1'($urandom_range(1)), t_now);
      end else begin
        send_request($urandom_range(3) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     t_now);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    snd_idle_pct = 11;
    rcv_idle_pct = 53;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    test_hold_off();

    load_random_config();
    test_random(RANDOM_ITEMS);

    snd_idle_pct = 53;
    rcv_idle_pct = 11;
    load_random_config();
    test_random(RANDOM_ITEMS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    load_random_config();
    test_random(RANDOM_ITEMS);

    // wait out owed responses, then watch for strays
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && pending_reports.size() == 0) begin
      $display("[quadrature_position_speed_decoder_top] OK");
    end else begin
      $display("[quadrature_position_speed_decoder_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("[quadrature_position_speed_decoder_top] ERROR");
    $finish;
  end

endmodule
